>>> hdl/handle_to_id_hash_table_defines.svh
// Assertion macros shared by the handle-to-id hash table RTL.
`ifndef HANDLE_TO_ID_HASH_TABLE_DEFINES_SVH
`define HANDLE_TO_ID_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HTID_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define HTID_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/htid_pkg.sv
// Package: field widths, status and request codes for the handle-to-id hash table.
package htid_pkg;

    localparam int unsigned HTID_SLOTS    = 256;

    localparam int unsigned KIND_W   = 2;
    localparam int unsigned HANDLE_W = 64;
    localparam int unsigned ID_W     = 23;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned SLOT_W   = 8;

    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam kind_t KIND_ADD    = 2'd0;
    localparam kind_t KIND_LOOKUP = 2'd1;
    localparam kind_t KIND_REMOVE = 2'd2;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_ABSENT  = 2'd1;
    localparam status_t ST_FULL    = 2'd2;
    localparam status_t ST_INVALID = 2'd3;

endpackage

>>> hdl/htid_ram.sv
// Generic single-write, single-read RAM with registered read data.
module htid_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/handle_to_id_hash_table.sv
// Top level: open-addressing handle-to-id hash table with linear probing.
//
// Input channel s_*: one request per item (kind, handle, thread_id); s_ready
// is high only while the block waits for a request. Output channel m_*: one
// result item per request (status, found_id, slot) from an output register.
// Requests are handled one at a time. Steps per item: accept, home-slot
// reduction (only when SLOTS is not a power of two; 8 bits per cycle), first
// read, then probes (one probe per cycle) over 1..SLOTS slots, then result
// load. Invalid requests skip the reduction, read and probes and go straight
// to the result load.
// Slot keys and ids share one RAM with registered reads; the probe
// rate is set by its single read port.
// After reset the block sweeps the RAM to zero, one slot per cycle, and
// accepts no request until done. A request may be accepted while the
// previous result still waits in the output register; a stalled receiver
// holds the next result in the engine until the output register frees.
`include "handle_to_id_hash_table_defines.svh"

module handle_to_id_hash_table
    import htid_pkg::*;
#(
    parameter int unsigned SLOTS = HTID_SLOTS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [KIND_W-1:0]   s_kind,
    input  logic [HANDLE_W-1:0] s_handle,
    input  logic [ID_W-1:0]     s_thread_id,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [ID_W-1:0]     m_found_id,
    output logic [SLOT_W-1:0]   m_slot
);

    localparam int unsigned IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam bit          IS_POW2 = (SLOTS == (1 << IDX_W));
    localparam int unsigned ENT_W   = HANDLE_W + ID_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [IDX_W-1:0]    clr_reg;
    logic [IDX_W-1:0]    idx_reg, idx_inc;
    logic [IDX_W-1:0]    probe_reg;
    logic [2:0]          chunk_reg;
    logic [HANDLE_W-1:0] hv_reg;
    logic [IDX_W-1:0]    rem_reg, rem_next;
    kind_t               kind_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [ID_W-1:0]     tid_reg;

    status_t             res_status_reg, res_status_next;
    logic [ID_W-1:0]     res_id_reg, res_id_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;

    logic                m_valid_reg;
    status_t             m_status_reg;
    logic [ID_W-1:0]     m_found_id_reg;
    logic [SLOT_W-1:0]   m_slot_reg;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr, ram_raddr;
    logic [ENT_W-1:0]    ram_wdata, ram_rdata;

    logic [HANDLE_W-1:0] rd_key;
    logic [ID_W-1:0]     rd_val;
    logic                key_empty, key_match, last_probe;
    logic                s_fire, req_bad, out_free;
    logic [IDX_W:0]      r_step;

    htid_ram #(
        .WIDTH(ENT_W),
        .DEPTH(SLOTS)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign s_ready    = (state_reg == S_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign req_bad    = (s_handle == '0) || (s_kind != KIND_ADD && s_kind != KIND_LOOKUP &&
                        s_kind != KIND_REMOVE) || (s_kind == KIND_ADD && s_thread_id == '0);
    assign out_free   = !m_valid_reg || m_ready;

    assign rd_key     = ram_rdata[ENT_W-1 -: HANDLE_W];
    assign rd_val     = ram_rdata[ID_W-1:0];
    assign key_empty  = (rd_key == '0);
    assign key_match  = (rd_key == handle_reg);
    assign last_probe = (probe_reg == IDX_W'(SLOTS - 1));
    assign idx_inc    = (idx_reg == IDX_W'(SLOTS - 1)) ? '0 : idx_reg + 1'b1;
    assign ram_raddr  = (state_reg == S_CHECK) ? idx_inc : idx_reg;

    // home slot reduction: eight bits of (handle >> 2) per cycle, MSB first
    always_comb begin
        r_step   = '0;
        rem_next = rem_reg;
        for (int b = 0; b < 8; b++) begin
            r_step = {rem_next, hv_reg[HANDLE_W-1-b]};
            if (r_step >= (IDX_W+1)'(SLOTS)) begin
                r_step = r_step - (IDX_W+1)'(SLOTS);
            end
            rem_next = r_step[IDX_W-1:0];
        end
    end

    always_comb begin
        state_next      = state_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = '0;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_slot_next   = res_slot_reg;
        case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                if (clr_reg == IDX_W'(SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    if (req_bad) begin
                        res_status_next = ST_INVALID;
                        res_id_next     = '0;
                        res_slot_next   = '0;
                        state_next      = S_DONE;
                    end else if (IS_POW2) begin
                        state_next = S_READ;
                    end else begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (chunk_reg == 3'd7) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                res_id_next   = '0;
                res_slot_next = '0;
                if (kind_reg == KIND_ADD) begin
                    if (key_empty || key_match) begin
                        ram_we          = 1'b1;
                        ram_wdata       = {handle_reg, tid_reg};
                        res_status_next = ST_OK;
                        res_slot_next   = SLOT_W'(idx_reg);
                        state_next      = S_DONE;
                    end else if (last_probe) begin
                        res_status_next = ST_FULL;
                        state_next      = S_DONE;
                    end
                end else begin
                    if (key_empty) begin
                        res_status_next = ST_ABSENT;
                        state_next      = S_DONE;
                    end else if (key_match) begin
                        res_status_next = ST_OK;
                        res_slot_next   = SLOT_W'(idx_reg);
                        if (kind_reg == KIND_LOOKUP) begin
                            res_id_next = rd_val;
                        end else begin
                            ram_we = 1'b1;
                        end
                        state_next = S_DONE;
                    end else if (last_probe) begin
                        res_status_next = ST_ABSENT;
                        state_next      = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_slot_reg   <= res_slot_next;
        if (s_fire) begin
            kind_reg   <= s_kind;
            handle_reg <= s_handle;
            tid_reg    <= s_thread_id;
            hv_reg     <= {2'b00, s_handle[HANDLE_W-1:2]};
            rem_reg    <= '0;
            chunk_reg  <= '0;
            probe_reg  <= '0;
            idx_reg    <= s_handle[IDX_W+1:2];
        end else if (state_reg == S_HASH) begin
            hv_reg    <= {hv_reg[HANDLE_W-9:0], 8'd0};
            rem_reg   <= rem_next;
            chunk_reg <= chunk_reg + 1'b1;
            if (chunk_reg == 3'd7) begin
                idx_reg <= rem_next;
            end
        end else if (state_reg == S_CHECK) begin
            idx_reg   <= idx_inc;
            probe_reg <= probe_reg + 1'b1;
        end
        if (state_reg == S_DONE && out_free) begin
            m_status_reg   <= res_status_reg;
            m_found_id_reg <= res_id_reg;
            m_slot_reg     <= res_slot_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_found_id = m_found_id_reg;
    assign m_slot     = m_slot_reg;

    `HTID_ASSERT_NOW(a_write_on_hit, (ram_we && state_reg == S_CHECK),
        (key_empty || key_match), "table write on a slot that neither matched nor was empty")
    `HTID_ASSERT_NEXT(a_accept_leaves_idle, s_fire,
        (state_reg != S_IDLE), "request accepted but engine stayed idle")
    `HTID_ASSERT_NOW(a_id_only_on_hit, m_valid,
        (m_found_id == '0 || m_status == ST_OK), "nonzero id on a failed request")
    `HTID_ASSERT_NOW(a_full_after_sweep,
        (state_reg == S_CHECK && state_next == S_DONE && res_status_next == ST_FULL),
        last_probe, "table full reported before every slot was probed")

endmodule
